/* src/bmf_pkg.sv */
package bmf_pkg;

    localparam int CH_W   = 16;
    localparam int CFG_W  = 10;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;
    localparam int SUM_W  = 20;  // nine 16-bit values
    localparam int DIV_W  = 4;   // divisor up to nine
    localparam int CNT_W  = 5;   // sequencer counter, holds SUM_W

    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 10'd64;
    localparam logic [0:0]       REG_SIZE       = 1'b0;

    typedef logic [CH_W-1:0] t_chan;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_rgb;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_SHIFT,
        ST_SUM,
        ST_DIV,
        ST_PUT,
        ST_STEP
    } t_state;

    typedef struct packed {
        logic       start;
        logic       shift;
        logic       acc;
        logic [1:0] col;
        logic       post;
        logic       div_load;
        logic       div_step;
        logic       put;
        logic       step;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic pre;
        logic post;
        logic out_free;
    } t_stat;

endpackage

/* src/bmf_in_if.sv */
interface bmf_in_if;
    import bmf_pkg::*;

    logic  valid;
    logic  ready;
    logic  opcode;
    t_chan in_red;
    t_chan in_green;
    t_chan in_blue;

    modport source (output valid, opcode, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, opcode, in_red, in_green, in_blue, output ready);
endinterface

/* src/bmf_out_if.sv */
interface bmf_out_if;
    import bmf_pkg::*;

    logic  valid;
    logic  ready;
    t_chan out_red;
    t_chan out_green;
    t_chan out_blue;
    logic  frame_end;

    modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

/* src/bmf_cfg.sv */
module bmf_cfg #(
    parameter int MAX_SIZE = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [bmf_pkg::ADDR_W-1:0]    i_paddr,
    input  logic [bmf_pkg::DATA_W-1:0]    i_pwdata,
    output logic [bmf_pkg::DATA_W-1:0]    o_prdata,
    output logic [$clog2(MAX_SIZE+1)-1:0] o_size,
    output logic                          o_wr
);
    import bmf_pkg::*;

    localparam int SW = $clog2(MAX_SIZE+1);

    logic [CFG_W-1:0] r_size;
    logic [0:0]       idx;
    logic [31:0]      wide;

    assign idx  = i_paddr[ADDR_W-1:2];
    assign o_wr = i_psel && i_penable && i_pwrite && (idx == REG_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= CFG_SIZE_RESET;
        end else if (o_wr) begin
            r_size <= i_pwdata[CFG_W-1:0];
        end
    end

    // zero acts as one, oversize saturates
    always_comb begin
        wide = 32'(r_size);
        if (wide == 32'd0) begin
            wide = 32'd1;
        end else if (wide > 32'(MAX_SIZE)) begin
            wide = 32'(MAX_SIZE);
        end
        o_size = wide[SW-1:0];
    end

    assign o_prdata = (idx == REG_SIZE) ? DATA_W'(r_size) : '0;

endmodule

/* src/bmf_ctrl.sv */
module bmf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_op,
    input  bmf_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output bmf_pkg::t_cmd  o_cmd
);
    import bmf_pkg::*;

    t_state          r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    logic            r_post;
    logic            r_made;
    logic            r_try;
    logic            r_drain;
    logic            ignore;

    assign ignore = (i_in_op == OP_PIXEL) ? i_stat.full : !i_stat.full;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid && !ignore) n_state = ST_READ;
            ST_READ:  n_state = ST_CHECK;
            ST_CHECK: n_state = i_stat.pre ? ST_SUM : ST_SHIFT;
            ST_SHIFT: n_state = i_stat.post ? ST_SUM : ST_STEP;
            ST_SUM:   if (r_cnt == CNT_W'(2)) n_state = ST_DIV;
            ST_DIV:   if (r_cnt == CNT_W'(SUM_W)) n_state = ST_PUT;
            ST_PUT:   if (i_stat.out_free) n_state = r_post ? ST_STEP : ST_SHIFT;
            ST_STEP:  n_state = (r_drain && !r_made && !r_try) ? ST_READ : ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.post = r_post;
        o_cmd.col  = r_cnt[1:0];
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid && !ignore;
            end
            ST_SHIFT: o_cmd.shift = 1'b1;
            ST_SUM:   o_cmd.acc = 1'b1;
            ST_DIV: begin
                o_cmd.div_load = (r_cnt == '0);
                o_cmd.div_step = (r_cnt != '0);
            end
            ST_PUT:  o_cmd.put = i_stat.out_free;
            ST_STEP: o_cmd.step = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_post  <= 1'b0;
            r_made  <= 1'b0;
            r_try   <= 1'b0;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state != n_state) begin
                r_cnt <= '0;
            end else if (r_state == ST_SUM || r_state == ST_DIV) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (o_cmd.start) begin
                r_made  <= 1'b0;
                r_try   <= 1'b0;
                r_drain <= (i_in_op == OP_DRAIN);
            end
            if (r_state == ST_CHECK) r_post <= 1'b0;
            if (r_state == ST_SHIFT) r_post <= 1'b1;
            if (o_cmd.put) r_made <= 1'b1;
            if (r_state == ST_STEP) r_try <= 1'b1;
        end
    end

endmodule

/* src/bmf_dp.sv */
module bmf_dp #(
    parameter int MAX_SIZE = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(MAX_SIZE+1)-1:0] i_size,
    input  logic                          i_cfg_wr,
    input  bmf_pkg::t_cmd                 i_cmd,
    output bmf_pkg::t_stat                o_stat,
    input  logic                          i_op,
    input  bmf_pkg::t_rgb                 i_px,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output bmf_pkg::t_rgb                 o_out_px,
    output logic                          o_frame_end
);
    import bmf_pkg::*;

    localparam int SW = $clog2(MAX_SIZE+1);
    localparam int AW = $clog2(MAX_SIZE);
    localparam int RW = SW + 1;
    localparam int PW = $bits(t_rgb);

    function automatic t_chan chan_of(t_rgb p, int ch);
        if (ch == 0) return p.red;
        if (ch == 1) return p.green;
        return p.blue;
    endfunction

    logic [AW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic            r_endf;
    logic            r_real;
    t_rgb            r_px;
    t_rgb            r_win [9];
    logic [2*PW-1:0] mem [MAX_SIZE];
    logic [2*PW-1:0] r_rd;
    logic [SUM_W-1:0] r_acc [3];
    logic [SUM_W-1:0] r_q [3];
    logic [DIV_W-1:0] r_rem [3];
    logic            r_ov;
    t_rgb            r_out;
    logic            r_out_end;

    logic [RW-1:0]    s_r;
    logic [SW-1:0]    s_m1;
    logic             past;
    logic [RW-1:0]    row_o;
    logic [AW-1:0]    col_o;
    logic [2:0]       cv;
    logic [2:0]       rv;
    logic [8:0]       mask;
    logic [DIV_W-1:0] cnt;
    logic             fend;
    logic [SUM_W-1:0] term [3];

    assign s_r  = RW'(i_size);
    assign s_m1 = i_size - SW'(1);
    assign past = (r_row >= RW'(2)) || ((r_row == RW'(1)) && (r_col != '0));

    assign o_stat.full     = (r_row >= s_r);
    assign o_stat.pre      = (r_col == '0) && past;
    assign o_stat.post     = (r_col != '0) && past;
    assign o_stat.out_free = !r_ov || i_out_ready;

    // neighbourhood of the output under work
    always_comb begin
        row_o = i_cmd.post ? (r_row - RW'(1)) : (r_row - RW'(2));
        col_o = i_cmd.post ? (r_col - AW'(1)) : AW'(s_m1);
        cv[0] = i_cmd.post && (RW'(r_col) >= RW'(2));
        cv[1] = i_cmd.post || (s_r >= RW'(2));
        cv[2] = 1'b1;
        rv[0] = (row_o != '0) && (row_o <= s_r);
        rv[1] = (row_o < s_r);
        rv[2] = ((row_o + RW'(1)) < s_r);
        cnt   = '0;
        for (int i = 0; i < 9; i++) begin
            mask[i] = cv[i/3] && rv[i%3];
            cnt     = cnt + DIV_W'(mask[i]);
        end
        if (cnt == '0) cnt = DIV_W'(1);
        fend = (row_o == s_r - RW'(1)) && (RW'(col_o) == s_r - RW'(1));
    end

    // one window column per accumulate cycle
    always_comb begin
        int idx;
        idx = 0;
        for (int ch = 0; ch < 3; ch++) begin
            term[ch] = '0;
            for (int r = 0; r < 3; r++) begin
                idx = int'(i_cmd.col) * 3 + r;
                if (idx < 9) begin
                    if (mask[idx]) term[ch] = term[ch] + SUM_W'(chan_of(r_win[idx], ch));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= mem[r_col];
        if (i_cmd.shift && r_real) begin
            mem[r_col] <= {r_rd[PW-1:0], r_px};
        end
    end

    always_ff @(posedge i_clk) begin
        logic [DIV_W:0] t;
        t = '0;
        if (i_cmd.start) begin
            r_real <= (i_op == OP_PIXEL);
            r_px   <= i_px;
        end
        if (i_cmd.shift) begin
            for (int i = 0; i < 6; i++) r_win[i] <= r_win[i+3];
            r_win[6] <= r_rd[2*PW-1:PW];
            r_win[7] <= r_rd[PW-1:0];
            r_win[8] <= r_real ? r_px : '0;
        end
        for (int ch = 0; ch < 3; ch++) begin
            if (i_cmd.acc) begin
                r_acc[ch] <= (i_cmd.col == 2'd0) ? term[ch] : r_acc[ch] + term[ch];
            end
            if (i_cmd.div_load) begin
                r_q[ch]   <= r_acc[ch];
                r_rem[ch] <= '0;
            end else if (i_cmd.div_step) begin
                t = {r_rem[ch], r_q[ch][SUM_W-1]};
                if (t >= {1'b0, cnt}) begin
                    t         = t - {1'b0, cnt};
                    r_q[ch]   <= {r_q[ch][SUM_W-2:0], 1'b1};
                end else begin
                    r_q[ch]   <= {r_q[ch][SUM_W-2:0], 1'b0};
                end
                r_rem[ch] <= t[DIV_W-1:0];
            end
        end
        if (i_cmd.put) begin
            r_out.red   <= r_q[0][CH_W-1:0];
            r_out.green <= r_q[1][CH_W-1:0];
            r_out.blue  <= r_q[2][CH_W-1:0];
            r_out_end   <= fend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr) begin
            r_col  <= '0;
            r_row  <= '0;
            r_endf <= 1'b0;
        end else begin
            if (i_cmd.put) r_endf <= fend;
            if (i_cmd.step) begin
                if (r_endf) begin
                    r_col  <= '0;
                    r_row  <= '0;
                    r_endf <= 1'b0;
                end else if (r_col == AW'(s_m1)) begin
                    r_col <= '0;
                    r_row <= r_row + RW'(1);
                end else begin
                    r_col <= r_col + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.put) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_px    = r_out;
    assign o_frame_end = r_out_end;

endmodule

/* src/box_mean_filter_3x3_rgb_unit.sv */
// 3x3 box mean filter over a square RGB image, 16 bits per channel.
// Input channel i_in: one item per pixel in raster order (opcode pixel), then
// drain items (opcode drain) after the last pixel to flush the pending
// outputs. A pixel past the end of the frame or a drain with the frame still
// open is taken and dropped. Output channel o_out: one item per image pixel,
// the truncated mean of its border-clipped 3x3 neighbourhood; frame_end marks
// the last output of the frame, after which the next pixel opens a new frame.
// Output n appears after input pixel n+size+1; the last size+1 outputs follow
// one per drain item.
// Items are handled one at a time: a new item is taken only once the last is
// done. An item that yields an output passes through a line store read, an
// accumulation over the three window columns and a bit-serial divide (load
// plus 20 steps) that runs for the three channels in parallel. A drain may
// step the window twice.
// APB register 0 (byte address 0): image_size, reset 64; writing it restarts
// the frame. Write it only while the block is idle.
// Reset (synchronous, active low) empties the output register and restarts
// the frame; the line store needs no clearing. A stalled receiver holds the
// output item in its register; the block takes the next input but holds
// before loading a new result until the old one is taken.
module box_mean_filter_3x3_rgb_unit #(
    parameter int MAX_SIZE = 512
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bmf_in_if.sink                      i_in,
    bmf_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bmf_pkg::ADDR_W-1:0]  paddr,
    input  logic [bmf_pkg::DATA_W-1:0]  pwdata,
    output logic [bmf_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import bmf_pkg::*;

    logic [$clog2(MAX_SIZE+1)-1:0] size;
    logic                          cfg_wr;
    t_cmd                          cmd;
    t_stat                         stat;
    t_rgb                          in_px;
    t_rgb                          out_px;

    assign pready = 1'b1;

    assign in_px.red   = i_in.in_red;
    assign in_px.green = i_in.in_green;
    assign in_px.blue  = i_in.in_blue;

    bmf_cfg #(.MAX_SIZE(MAX_SIZE)) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_psel   (psel),
        .i_penable(penable),
        .i_pwrite (pwrite),
        .i_paddr  (paddr),
        .i_pwdata (pwdata),
        .o_prdata (prdata),
        .o_size   (size),
        .o_wr     (cfg_wr)
    );

    // sequencer: accept, read line store, produce, shift window, advance
    bmf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .i_in_op   (i_in.opcode),
        .i_stat    (stat),
        .o_in_ready(i_in.ready),
        .o_cmd     (cmd)
    );

    // window, line store, accumulators, divider and output register
    bmf_dp #(.MAX_SIZE(MAX_SIZE)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_size     (size),
        .i_cfg_wr   (cfg_wr),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_op       (i_in.opcode),
        .i_px       (in_px),
        .i_out_ready(o_out.ready),
        .o_out_valid(o_out.valid),
        .o_out_px   (out_px),
        .o_frame_end(o_out.frame_end)
    );

    assign o_out.out_red   = out_px.red;
    assign o_out.out_green = out_px.green;
    assign o_out.out_blue  = out_px.blue;

endmodule
